// File: rtl/assert_macros.svh
// Assertion macros used by the checker file pds_checker.sv.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pds_pkg.sv
// Package for the distinct prime factor sum block.
// Holds the control state type and fixed constants; no dependencies.
package pds_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  localparam int FIRST_ODD  = 3;
  localparam int TRIAL_STEP = 2;
  localparam int EVEN_PRIME = 2;

endpackage

// File: rtl/pds_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; used by prime_divisor_sum_top for trial division.
module pds_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/prime_divisor_sum_top.sv
// Sum of distinct prime factors by odd trial division, W = VALUE_WIDTH.
// Inputs 0 and 1 give their result straight from idle; otherwise factors of two are
// stripped first, then each trial division is run through the bit-serial divider.
// One item at a time: busy drops with the result strobe, next start taken in that cycle.
// Reset (synchronous, rst_n low) returns to idle and drops busy and out_valid.
module prime_divisor_sum_top #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value_in,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_prime_sum
);

  localparam int W = VALUE_WIDTH;

  pds_pkg::state_t state_r, state_nxt;
  logic         inner_r, inner_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W-1:0] total_r, total_nxt;
  logic [W-1:0] out_sum_r, out_sum_nxt;
  logic         div_go;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  pds_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (n_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    inner_nxt     = inner_r;
    out_valid_nxt = 1'b0;
    n_nxt         = n_r;
    d_nxt         = d_r;
    total_nxt     = total_r;
    out_sum_nxt   = out_sum_r;
    div_go        = 1'b0;
    case (state_r)
      pds_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt     = in_value_in;
          d_nxt     = W'(pds_pkg::FIRST_ODD);
          inner_nxt = 1'b0;
          total_nxt = in_value_in[0] ? '0 : W'(pds_pkg::EVEN_PRIME);
          if (in_value_in[W-1:1] == '0) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
          end else begin
            state_nxt = pds_pkg::ST_STRIP;
          end
        end
      end
      pds_pkg::ST_STRIP: begin
        if (!n_r[0]) begin
          n_nxt = {1'b0, n_r[W-1:1]};
        end else begin
          state_nxt = pds_pkg::ST_DIV_GO;
        end
      end
      pds_pkg::ST_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = pds_pkg::ST_DIV_WAIT;
      end
      pds_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = pds_pkg::ST_DIV_GO;
          if (inner_r) begin
            if (div_rem == '0) begin
              n_nxt = div_quo;
            end else begin
              inner_nxt = 1'b0;
              d_nxt     = d_r + W'(pds_pkg::TRIAL_STEP);
            end
          end else if (d_r > div_quo) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = (n_r[W-1:1] != '0) ? total_r + n_r : total_r;
            state_nxt     = pds_pkg::ST_IDLE;
          end else if (div_rem == '0) begin
            total_nxt = total_r + d_r;
            n_nxt     = div_quo;
            inner_nxt = 1'b1;
          end else begin
            d_nxt = d_r + W'(pds_pkg::TRIAL_STEP);
          end
        end
      end
      default: begin
        state_nxt = pds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pds_pkg::ST_IDLE;
      inner_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inner_r     <= inner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    total_r   <= total_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign busy          = (state_r != pds_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_prime_sum = out_sum_r;

endmodule

// File: rtl/pds_checker.sv
// Port-level checks on the start/busy/out_valid timing of the top level.
// Uses assert_macros.svh; bound to prime_divisor_sum_top below.
`include "assert_macros.svh"

module pds_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `PDS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "accept gave no work")
  `PDS_ASSERT_NEXT(a_busy_ends_in_result, busy, busy || out_valid, "busy dropped without result")
  `PDS_ASSERT_NOW(a_result_idle, out_valid, !busy, "result strobe while busy")
  `PDS_ASSERT_NOW(a_result_has_cause, out_valid, $past(busy || start), "unprompted result")

endmodule

bind prime_divisor_sum_top pds_checker u_pds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
